>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock unless reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");
`endif

>>> rtl/odh_pkg.sv
// package for the ordered dither halftone block: constants, types, helpers
// no dependencies
`timescale 1ns / 1ps
package odh_pkg;
   localparam int MAX_BLOCK  = 4;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int BS_CAP     = (MAX_BLOCK < 4) ? MAX_BLOCK : 4;
   localparam int POS_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int SUM_W      = 12;

   // floor(v / 3) as (v * 683) >> 11, exact for every v below 1024
   localparam int RECIP3     = 683;
   localparam int RECIP3_SH  = 11;
   localparam int PROD_W     = POS_W + 10;

   typedef enum logic [2:0] {
      CSR_WIDTH = 3'd0, CSR_HEIGHT = 3'd1, CSR_BSIZE = 3'd2, CSR_MODE = 3'd3,
      CSR_THR0 = 3'd4, CSR_THR1 = 3'd5, CSR_THR2 = 3'd6, CSR_THR3 = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      MODE_DITHER = 2'd0, MODE_ENLARGE = 2'd1, MODE_BLOCK = 2'd2, MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_LEVEL, ST_EMIT
   } state_type;

   // line store command from control to memory
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [SUM_W-1:0]  wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;
endpackage

>>> rtl/odh_line_store.sv
// line store of block sums, one synchronous read and one write port
// depends on odh_pkg
`timescale 1ns / 1ps
module odh_line_store import odh_pkg::*; (
   input  logic             clock,
   input  mem_cmd_type      cmd,
   output logic [SUM_W-1:0] rd_data
);
   logic [SUM_W-1:0] mem [MAX_WIDTH];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> rtl/odh_level.sv
// level unit: floor((s*(n+1)-c)/(255*c)) by restoring division, one bit a cycle
// depends on odh_pkg
`timescale 1ns / 1ps
module odh_level import odh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] sum,
   input  logic [4:0]       count,
   input  logic [4:0]       n,
   output logic             busy,
   output logic [4:0]       level
);
   // quotient never exceeds n, so five bits suffice
   localparam int NUM_W = 18;
   localparam int DEN_W = 13;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [4:0]       q_ff, q_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [NUM_W-1:0] trial;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      if (start) begin
         if (sum == '0) begin
            rem_in = '0;
         end else begin
            rem_in = NUM_W'(sum) * NUM_W'({1'b0, n} + 6'd1) - NUM_W'(count);
         end
         den_in = DEN_W'(count) * DEN_W'(255);
         q_in = '0;
         cnt_in = 3'd4;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = NUM_W'(den_ff) << cnt_ff;
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            q_in = q_ff | (5'd1 << cnt_ff);
         end
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
   end
   assign busy = busy_ff;
   assign level = q_ff;
endmodule

>>> rtl/ordered_dither_halftone.sv
// ordered dither halftone engine, top level
// a pixel passes through read, level divide and emit; its k results (1..16) leave at one
// per cycle while rsp_stall is low, bounded by the serial level divider and the single
// result register; a new pixel is taken only once the last result is registered; a
// block-mode pixel that closes no block returns to idle after read and level, and a
// mode-three pixel stays in idle; reset: synchronous; clears the 1024-entry line store
// after reset and any width, height, block size or mode write, taking no pixel meanwhile
`timescale 1ns / 1ps
module ordered_dither_halftone import odh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_out_row,
   output logic [11:0] rsp_out_col,
   output logic        rsp_bit_res,
   output logic        rsp_last_of_run
);
   logic [10:0] width_ff, height_ff;
   logic [2:0]  bsize_ff;
   logic [1:0]  mode_ff;
   logic [19:0] thr_ff [4];

   state_type   state_ff, state_in;
   logic [POS_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [7:0]  px_ff, px_in;
   // emission geometry
   logic [POS_W-1:0] r0_ff, r0_in, c0_ff, c0_in;
   logic [2:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [1:0]  ei_ff, ei_in, ej_ff, ej_in;
   logic        blk_ff, blk_in;
   logic [2:0]  wait_ff, wait_in;
   logic        out_v_ff, out_v_in;
   logic [11:0] out_r_ff, out_r_in, out_c_ff, out_c_in;
   logic        out_b_ff, out_b_in, out_l_ff, out_l_in;

   mem_cmd_type mcmd;
   logic [SUM_W-1:0] rd_data;
   logic        lv_start, lv_busy;
   logic [4:0]  level;
   logic [SUM_W-1:0] lv_sum;
   logic [4:0]  lv_count;

   // clamped geometry
   logic [10:0] w, h;
   logic [2:0]  bs;
   logic [4:0]  n;
   always_comb begin
      w = (width_ff == '0) ? 11'd1 : (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
      h = (height_ff == '0) ? 11'd1 :
          (height_ff > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_ff;
      bs = (bsize_ff == '0) ? 3'd1 : (bsize_ff > 3'(BS_CAP)) ? 3'(BS_CAP) : bsize_ff;
      n = 5'(bs) * 5'(bs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd1024;
         height_ff <= 11'd1024;
         bsize_ff <= 3'd4;
         mode_ff <= MODE_DITHER;
         for (int k = 0; k < 4; k++) thr_ff[k] <= '0;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_WIDTH:  width_ff <= csr_data[10:0];
            CSR_HEIGHT: height_ff <= csr_data[10:0];
            CSR_BSIZE:  bsize_ff <= csr_data[2:0];
            CSR_MODE:   mode_ff <= csr_data[1:0];
            default:    thr_ff[csr_index[1:0]] <= csr_data;
         endcase
      end
   end

   logic geo_write;
   assign geo_write = csr_write && !csr_index[2];

   // position inside block: for block size three, divide by three through a reciprocal multiply
   logic [POS_W-1:0] bc0, br0, x, y;
   logic [PROD_W-1:0] x_prod, y_prod;
   logic [POS_W-1:0] x_div3, y_div3;
   logic [2:0] rem_c, rem_r;
   logic [2:0] clip_r, clip_c;
   logic [10:0] left_r, left_c;
   logic        blk_end;
   always_comb begin
      x = (11'(row_ff) >= h || 11'(col_ff) >= w) ? '0 : row_ff;
      y = (11'(row_ff) >= h || 11'(col_ff) >= w) ? '0 : col_ff;
      x_prod = PROD_W'(x) * PROD_W'(RECIP3);
      y_prod = PROD_W'(y) * PROD_W'(RECIP3);
      x_div3 = POS_W'(x_prod >> RECIP3_SH);
      y_div3 = POS_W'(y_prod >> RECIP3_SH);
      case (bs)
         3'd2: begin rem_r = {2'b0, x[0]}; rem_c = {2'b0, y[0]}; end
         3'd3: begin
            rem_r = 3'(x - POS_W'(3) * x_div3);
            rem_c = 3'(y - POS_W'(3) * y_div3);
         end
         3'd4: begin rem_r = {1'b0, x[1:0]}; rem_c = {1'b0, y[1:0]}; end
         default: begin rem_r = 3'd0; rem_c = 3'd0; end
      endcase
      br0 = x - POS_W'(rem_r);
      bc0 = y - POS_W'(rem_c);
      left_r = h - 11'(br0);
      left_c = w - 11'(bc0);
      clip_r = (left_r < 11'(bs)) ? left_r[2:0] : bs;
      clip_c = (left_c < 11'(bs)) ? left_c[2:0] : bs;
      blk_end = (rem_r == clip_r - 3'd1) && (rem_c == clip_c - 3'd1);
   end

   // block column index y / bs
   logic [ADDR_W-1:0] bidx;
   always_comb begin
      case (bs)
         3'd2: bidx = ADDR_W'(y >> 1);
         3'd3: bidx = ADDR_W'(y_div3);
         3'd4: bidx = ADDR_W'(y >> 2);
         default: bidx = ADDR_W'(y);
      endcase
   end

   logic [ADDR_W-1:0] bidx_ff, bidx_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [4:0] thr_e;
   logic [1:0] ti, tj;

   always_comb begin
      state_in = state_ff;
      row_in = row_ff; col_in = col_ff; clr_in = clr_ff; px_in = px_ff;
      r0_in = r0_ff; c0_in = c0_ff; rows_in = rows_ff; cols_in = cols_ff;
      ei_in = ei_ff; ej_in = ej_ff; blk_in = blk_ff; wait_in = wait_ff;
      bidx_in = bidx_ff; sum_in = sum_ff;
      out_v_in = out_v_ff; out_r_in = out_r_ff; out_c_in = out_c_ff;
      out_b_in = out_b_ff; out_l_in = out_l_ff;
      mcmd = '0;
      mcmd.rd_addr = bidx;
      lv_start = 1'b0;
      lv_sum = sum_ff;
      lv_count = 5'(rows_ff) * 5'(cols_ff);
      req_stall = 1'b1;
      ti = '0; tj = '0;
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mcmd.wr_en = 1'b1;
            mcmd.wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAX_WIDTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               px_in = req_pixel;
               bidx_in = bidx;
               blk_in = blk_end;
               r0_in = (mode_ff == MODE_BLOCK) ? br0 : x;
               c0_in = (mode_ff == MODE_BLOCK) ? bc0 : y;
               rows_in = (mode_ff == MODE_BLOCK) ? clip_r : 3'd1;
               cols_in = (mode_ff == MODE_BLOCK) ? clip_c : 3'd1;
               // dither mode stores in-block offsets in ei/ej
               ei_in = (mode_ff == MODE_DITHER) ? rem_r[1:0] : 2'd0;
               ej_in = (mode_ff == MODE_DITHER) ? rem_c[1:0] : 2'd0;
               if (11'(y) + 11'd1 >= w) begin
                  col_in = '0;
                  row_in = (11'(x) + 11'd1 >= h) ? '0 : x + 1'b1;
               end else begin
                  col_in = y + 1'b1;
                  row_in = x;
               end
               state_in = (mode_ff == MODE_NONE) ? ST_IDLE : ST_READ;
            end
         end
         ST_READ: begin
            if (mode_ff == MODE_BLOCK) begin
               sum_in = rd_data + SUM_W'(px_ff);
               mcmd.wr_en = 1'b1;
               mcmd.wr_addr = bidx_ff;
               mcmd.wr_data = blk_ff ? '0 : rd_data + SUM_W'(px_ff);
            end else begin
               sum_in = SUM_W'(px_ff);
               blk_in = 1'b1;
            end
            if (mode_ff == MODE_ENLARGE) begin
               rows_in = bs; cols_in = bs;
            end
            state_in = ST_LEVEL;
            wait_in = 3'd0;
         end
         ST_LEVEL: begin
            if (!blk_ff) begin
               state_in = ST_IDLE;
            end else if (wait_ff == 3'd0) begin
               lv_count = (mode_ff == MODE_BLOCK) ? 5'(rows_ff) * 5'(cols_ff) : 5'd1;
               lv_start = 1'b1;
               wait_in = 3'd1;
            end else if (!lv_busy) begin
               state_in = ST_EMIT;
               if (mode_ff != MODE_DITHER) begin
                  ei_in = '0; ej_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (!out_v_ff || !rsp_stall) begin
               ti = ei_ff; tj = ej_ff;
               out_v_in = 1'b1;
               out_b_in = !(thr_e > level);
               if (mode_ff == MODE_DITHER) begin
                  out_r_in = 12'(r0_ff); out_c_in = 12'(c0_ff);
                  out_l_in = 1'b1;
               end else if (mode_ff == MODE_ENLARGE) begin
                  out_r_in = 12'(r0_ff) * 12'(bs) + 12'(ei_ff);
                  out_c_in = 12'(c0_ff) * 12'(bs) + 12'(ej_ff);
                  out_l_in = (3'(ei_ff) == rows_ff - 3'd1) && (3'(ej_ff) == cols_ff - 3'd1);
               end else begin
                  out_r_in = 12'(r0_ff) + 12'(ei_ff);
                  out_c_in = 12'(c0_ff) + 12'(ej_ff);
                  out_l_in = (3'(ei_ff) == rows_ff - 3'd1) && (3'(ej_ff) == cols_ff - 3'd1);
               end
               if (out_l_in) begin
                  state_in = ST_IDLE;
               end else if (3'(ej_ff) == cols_ff - 3'd1) begin
                  ej_in = '0; ei_in = ei_ff + 1'b1;
               end else begin
                  ej_in = ej_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (geo_write) begin
         state_in = ST_CLEAR;
         clr_in = '0;
         row_in = '0;
         col_in = '0;
      end
   end

   assign thr_e = 5'(thr_ff[ti] >> (5 * tj));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         out_v_ff <= 1'b0;
         wait_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         row_ff <= row_in;
         col_ff <= col_in;
         out_v_ff <= out_v_in;
         wait_ff <= wait_in;
      end
      px_ff <= px_in; r0_ff <= r0_in; c0_ff <= c0_in;
      rows_ff <= rows_in; cols_ff <= cols_in; ei_ff <= ei_in; ej_ff <= ej_in;
      blk_ff <= blk_in; bidx_ff <= bidx_in; sum_ff <= sum_in;
      out_r_ff <= out_r_in; out_c_ff <= out_c_in;
      out_b_ff <= out_b_in; out_l_ff <= out_l_in;
   end

   odh_line_store u_store (
      .clock   (clock),
      .cmd     (mcmd),
      .rd_data (rd_data)
   );

   odh_level u_level (
      .clock (clock),
      .reset (reset),
      .start (lv_start),
      .sum   (lv_sum),
      .count (lv_count),
      .n     (n),
      .busy  (lv_busy),
      .level (level)
   );

   assign rsp_valid = out_v_ff;
   assign rsp_out_row = out_r_ff;
   assign rsp_out_col = out_c_ff;
   assign rsp_bit_res = out_b_ff;
   assign rsp_last_of_run = out_l_ff;
endmodule

>>> rtl/odh_checker.sv
// port-level checks for the halftone engine, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module odh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_out_row,
   input logic [11:0] rsp_out_col,
   input logic        rsp_bit_res,
   input logic        rsp_last_of_run
);
   // a stalled result stays valid and keeps its row, column and bit
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_bit_res))
   // no new pixel is taken while a result other than the last of its run is valid
   `ASSERT_IMPL(a_no_take_while_out, clock, reset, rsp_valid && !rsp_last_of_run,
      req_stall)
   // a pixel transfer made while no result is valid is never followed directly by a result
   `ASSERT_NEXT(a_gap, clock, reset, req_valid && !req_stall && !rsp_valid, !rsp_valid)
endmodule

bind ordered_dither_halftone odh_checker u_odh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_row     (rsp_out_row),
   .rsp_out_col     (rsp_out_col),
   .rsp_bit_res     (rsp_bit_res),
   .rsp_last_of_run (rsp_last_of_run)
);

>>> bench/tb.sv
// self-checking bench for ordered_dither_halftone: directed then random pixel streams
// predicts each halftone result in-bench; depends on odh_pkg and the rtl top level
`timescale 1ns / 1ps
module tb;
   import odh_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;

   typedef struct {
      logic [11:0] row;
      logic [11:0] col;
      logic        bit_res;
      logic        last;
   } halftone_bit_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [19:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_out_row;
   logic [11:0] rsp_out_col;
   logic        rsp_bit_res;
   logic        rsp_last_of_run;

   ordered_dither_halftone u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and state
   logic [10:0] img_w, img_h;
   logic [2:0]  blk_size;
   logic [1:0]  cur_mode;
   logic [19:0] thr_row [4];
   int unsigned pos_row, pos_col;
   int unsigned line_sums [MAX_WIDTH];

   logic [7:0]    pixel_q [$];
   halftone_bit_t halftone_q [$];
   int unsigned   fail_cnt, pixel_cnt, bit_cnt, cycle_cnt;

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned thr_entry(int unsigned i, int unsigned j);
      return (thr_row[i & 3] >> (5 * (j & 3))) & 31;
   endfunction

   function automatic int unsigned grey_level(int unsigned sum, int unsigned cnt,
                                              int unsigned n);
      if (sum == 0 || cnt == 0) return 0;
      return (sum * (n + 1) - cnt) / (255 * cnt);
   endfunction

   function automatic void clear_frame();
      pos_row = 0;
      pos_col = 0;
      foreach (line_sums[k]) line_sums[k] = 0;
   endfunction

   // computes the halftone bits one pixel produces and queues them
   function automatic void predict_halftone(logic [7:0] px);
      int unsigned w, h, bs, n, x, y, lvl, first, bx, r0, c0, nr, nc;
      halftone_bit_t hb;
      w = clampu(img_w, 1, MAX_WIDTH);
      h = clampu(img_h, 1, MAX_HEIGHT);
      bs = clampu(blk_size, 1, BS_CAP);
      n = bs * bs;
      x = pos_row;
      y = pos_col;
      if (x >= h || y >= w) begin
         x = 0;
         y = 0;
      end
      first = halftone_q.size();
      hb.last = 1'b0;
      if (cur_mode == MODE_DITHER) begin
         lvl = grey_level(px, 1, n);
         hb.row = x;
         hb.col = y;
         hb.bit_res = !(thr_entry(x % bs, y % bs) > lvl);
         halftone_q.push_back(hb);
      end else if (cur_mode == MODE_ENLARGE) begin
         lvl = grey_level(px, 1, n);
         for (int i = 0; i < bs; i++)
            for (int j = 0; j < bs; j++) begin
               hb.row = bs * x + i;
               hb.col = bs * y + j;
               hb.bit_res = !(thr_entry(i, j) > lvl);
               halftone_q.push_back(hb);
            end
      end else if (cur_mode == MODE_BLOCK) begin
         bx = y / bs;
         r0 = (x / bs) * bs;
         c0 = bx * bs;
         nr = (h - r0 < bs) ? h - r0 : bs;
         nc = (w - c0 < bs) ? w - c0 : bs;
         line_sums[bx % MAX_WIDTH] += px;
         if (x == r0 + nr - 1 && y == c0 + nc - 1) begin
            lvl = grey_level(line_sums[bx % MAX_WIDTH], nr * nc, n);
            for (int i = 0; i < nr; i++)
               for (int j = 0; j < nc; j++) begin
                  hb.row = r0 + i;
                  hb.col = c0 + j;
                  hb.bit_res = !(thr_entry(i, j) > lvl);
                  halftone_q.push_back(hb);
               end
            line_sums[bx % MAX_WIDTH] = 0;
         end
      end
      if (halftone_q.size() > first) halftone_q[$].last = 1'b1;
      y++;
      if (y >= w) begin
         y = 0;
         x++;
         if (x >= h) x = 0;
      end
      pos_row = x;
      pos_col = y;
   endfunction

   // driver: bursts of transfers separated by random gaps
   int unsigned burst_left = 1, gap_left = 0;
   always @(negedge clock) begin
      logic       nxt_valid;
      logic [7:0] nxt_pixel;
      nxt_valid = req_valid;
      nxt_pixel = req_pixel;
      if (!reset && !(req_valid && req_stall)) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pixel_q.size() > 0) begin
            nxt_valid = 1'b1;
            nxt_pixel = pixel_q.pop_front();
            if (--burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      req_valid <= nxt_valid;
      req_pixel <= nxt_pixel;
   end

   // receiver stall pattern: random stalls at a percentage that is redrawn as cycle_cnt advances
   int unsigned stall_pct = 0;
   always @(negedge clock) begin
      if (cycle_cnt % 64 == 0) stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // monitor: predicts on each accepted pixel, checks each result transfer
   always @(posedge clock) begin
      halftone_bit_t exp_bit;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("ordered_dither_halftone verification failed");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pixel_cnt++;
            predict_halftone(req_pixel);
         end
         if (rsp_valid && !rsp_stall) begin
            bit_cnt++;
            if (halftone_q.size() == 0) begin
               $error("unexpected result row %0d col %0d", rsp_out_row, rsp_out_col);
               fail_cnt++;
            end else begin
               exp_bit = halftone_q.pop_front();
               if (rsp_out_row !== exp_bit.row) begin
                  $error("out_row expected %0d got %0d", exp_bit.row, rsp_out_row);
                  fail_cnt++;
               end
               if (rsp_out_col !== exp_bit.col) begin
                  $error("out_col expected %0d got %0d", exp_bit.col, rsp_out_col);
                  fail_cnt++;
               end
               if (rsp_bit_res !== exp_bit.bit_res) begin
                  $error("bit_res expected %0d got %0d", exp_bit.bit_res, rsp_bit_res);
                  fail_cnt++;
               end
               if (rsp_last_of_run !== exp_bit.last) begin
                  $error("last_of_run expected %0d got %0d", exp_bit.last, rsp_last_of_run);
                  fail_cnt++;
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_valid || halftone_q.size() > 0) @(posedge clock);
      // mode three pixels leave nothing to wait on, so let the pipeline settle
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_wr(csr_idx_type idx, logic [19:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_WIDTH:  begin img_w = val[10:0]; clear_frame(); end
         CSR_HEIGHT: begin img_h = val[10:0]; clear_frame(); end
         CSR_BSIZE:  begin blk_size = val[2:0]; clear_frame(); end
         CSR_MODE:   begin cur_mode = val[1:0]; clear_frame(); end
         default:    thr_row[idx - CSR_THR0] = val;
      endcase
   endtask

   task automatic setup_frame(logic [19:0] w, logic [19:0] h, logic [19:0] bs,
                              mode_type m, logic rand_thr);
      csr_wr(CSR_WIDTH, w);
      csr_wr(CSR_HEIGHT, h);
      csr_wr(CSR_BSIZE, bs);
      csr_wr(CSR_MODE, m);
      if (rand_thr) begin
         csr_wr(CSR_THR0, $urandom);
         csr_wr(CSR_THR1, $urandom);
         csr_wr(CSR_THR2, $urandom);
         csr_wr(CSR_THR3, $urandom);
      end
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   initial begin
      mode_type m;
      img_w = 11'd1024;
      img_h = 11'd1024;
      blk_size = 3'd4;
      cur_mode = MODE_DITHER;
      foreach (thr_row[k]) thr_row[k] = '0;
      clear_frame();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry, all-zero matrix
      pixel_q = '{8'd0, 8'd255, 8'd1};
      wait_drained();

      // small dither frame wrapping around, extreme thresholds
      csr_wr(CSR_THR0, 20'hFFFFF);
      csr_wr(CSR_THR1, 20'h00000);
      csr_wr(CSR_THR2, 20'h08421);
      csr_wr(CSR_THR3, 20'hF7BDE);
      setup_frame(3, 2, 4, MODE_DITHER, 1'b0);
      pixel_q = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd17, 8'd200};
      wait_drained();

      // enlarge, block size zero then full size
      setup_frame(2, 2, 0, MODE_ENLARGE, 1'b0);
      pixel_q = '{8'd255, 8'd0};
      wait_drained();
      setup_frame(2, 2, 4, MODE_ENLARGE, 1'b1);
      pixel_q = '{8'd64, 8'd255};
      wait_drained();

      // block mode: zero geometry, oversized block size, clipped edges
      setup_frame(0, 0, 7, MODE_BLOCK, 1'b0);
      pixel_q = '{8'd255, 8'd3};
      wait_drained();
      setup_frame(5, 3, 3, MODE_BLOCK, 1'b1);
      repeat (15) pixel_q.push_back(rand_pixel());
      wait_drained();

      // mode three and oversized geometry: nothing comes out, position moves
      setup_frame(20'h007FF, 20'h007FF, 2, MODE_NONE, 1'b0);
      pixel_q = '{8'd9, 8'd99};
      wait_drained();
      setup_frame(1024, 1024, 1, MODE_DITHER, 1'b0);
      pixel_q = '{8'd128};
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         m = ($urandom_range(0, 9) == 0) ? MODE_NONE : mode_type'($urandom_range(0, 2));
         setup_frame($urandom_range(1, 7), $urandom_range(1, 6),
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                     m, 1'b1);
         repeat (6) pixel_q.push_back(rand_pixel());
         // hold off mid-frame until every result is back
         if (ph == 2) wait_drained();
         repeat (6) pixel_q.push_back(rand_pixel());
         wait_drained();
      end

      $display("covered %0d pixels in all four modes and %0d halftone results",
               pixel_cnt, bit_cnt);
      $display("geometry and block size clamping, clipped blocks, frame wrap included");
      if (fail_cnt == 0 && halftone_q.size() == 0)
         $display("ordered_dither_halftone verification clean");
      else
         $display("ordered_dither_halftone verification failed");
      $finish;
   end
endmodule

>>> ordered_dither_halftone.f
+incdir+rtl
rtl/odh_pkg.sv
rtl/odh_line_store.sv
rtl/odh_level.sv
rtl/ordered_dither_halftone.sv
rtl/odh_checker.sv
bench/tb.sv
